// ===== design/b64pem_pkg.sv =====
package b64pem_pkg;

   localparam int LineCharsDefault = 64;
   localparam int SymMax           = 4;
   localparam int QueueDepth       = 4;
   localparam int MaxResults       = 5;

   localparam logic [6:0] CharNewline = 7'h0A;
   localparam logic [6:0] CharPad     = 7'h3D;

   typedef struct packed {
      logic [SymMax-1:0][6:0] sym;
      logic [2:0]             nsym;
      logic                   last;
   } b64pem_entry_type;

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] c;
      if (v < 6'd26) begin
         c = 7'd65 + {1'b0, v};
      end else if (v < 6'd52) begin
         c = 7'd71 + {1'b0, v};
      end else if (v < 6'd62) begin
         c = {1'b0, v} - 7'd4;
      end else if (v == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

endpackage

// ===== design/b64pem_front.sv =====
module b64pem_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,
   input  logic                         req_tlast,
   output logic                         push_valid,
   input  logic                         push_ready,
   output b64pem_pkg::b64pem_entry_type push_entry
);
   import b64pem_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;
   logic       fire;
   b64pem_entry_type entry;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign fire       = req_tvalid & push_ready;
   assign push_entry = entry;

   always_comb begin
      entry.sym  = '0;
      entry.nsym = 3'd1;
      entry.last = req_tlast;
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      case (phase_ff)
         2'd0: begin
            entry.sym[0] = b64_char(req_tdata[7:2]);
            leftover_in  = {2'b00, req_tdata[1:0]};
            phase_in     = 2'd1;
            if (req_tlast) begin
               entry.sym[1] = b64_char({req_tdata[1:0], 4'b0000});
               entry.sym[2] = CharPad;
               entry.sym[3] = CharPad;
               entry.nsym   = 3'd4;
            end
         end
         2'd1: begin
            entry.sym[0] = b64_char({leftover_ff[1:0], req_tdata[7:4]});
            leftover_in  = req_tdata[3:0];
            phase_in     = 2'd2;
            if (req_tlast) begin
               entry.sym[1] = b64_char({req_tdata[3:0], 2'b00});
               entry.sym[2] = CharPad;
               entry.nsym   = 3'd3;
            end
         end
         default: begin
            entry.sym[0] = b64_char({leftover_ff, req_tdata[7:6]});
            entry.sym[1] = b64_char(req_tdata[5:0]);
            entry.nsym   = 3'd2;
            leftover_in  = 4'd0;
            phase_in     = 2'd0;
         end
      endcase
      if (req_tlast) begin
         phase_in    = 2'd0;
         leftover_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 2'd0;
         leftover_ff <= 4'd0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

endmodule

// ===== design/b64pem_queue.sv =====
module b64pem_queue #(
   parameter int DEPTH = b64pem_pkg::QueueDepth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   output logic                         push_ready,
   input  b64pem_pkg::b64pem_entry_type push_entry,
   output logic                         head_valid,
   input  logic                         pop,
   output b64pem_pkg::b64pem_entry_type head_entry
);
   import b64pem_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   b64pem_entry_type slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/b64pem_back.sv =====
module b64pem_back #(
   parameter int LINE_CHARS = b64pem_pkg::LineCharsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  b64pem_pkg::b64pem_entry_type head_entry,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic                         rsp_tlast
);
   import b64pem_pkg::*;

   localparam int ColW = $clog2(LINE_CHARS);

   logic [ColW-1:0] col_ff, col_in;
   logic [2:0]      idx_ff, idx_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            nl_pend_ff, nl_pend_in;
   logic            out_valid_ff, out_valid_in;
   logic [6:0]      out_char_ff, ch;
   logic            out_last_ff, lst;
   logic            fire, wrap;
   logic [2:0]      idx_next;

   assign fire     = head_valid & (~out_valid_ff | rsp_tready);
   assign idx_next = idx_ff + 3'd1;
   assign wrap     = (col_ff == ColW'(LINE_CHARS - 1));

   always_comb begin
      ch         = CharNewline;
      lst        = 1'b0;
      pop        = 1'b0;
      col_in     = col_ff;
      idx_in     = idx_ff;
      nl_pend_in = nl_pend_ff;
      if (nl_pend_ff) begin
         nl_pend_in = 1'b0;
         if (idx_ff == head_entry.nsym) begin
            pop = 1'b1;
            lst = head_entry.last;
         end
      end else if (idx_ff != head_entry.nsym) begin
         ch     = head_entry.sym[idx_ff[1:0]];
         idx_in = idx_next;
         if (wrap) begin
            col_in     = '0;
            nl_pend_in = 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
            if (idx_next == head_entry.nsym && !head_entry.last) begin
               pop = 1'b1;
            end
         end
      end else begin
         lst    = 1'b1;
         pop    = 1'b1;
         col_in = '0;
      end
      // at most five characters leave for one byte; the fifth closes the message
      if (cnt_ff == 3'(MaxResults - 1)) begin
         lst        = 1'b1;
         pop        = 1'b1;
         col_in     = '0;
         nl_pend_in = 1'b0;
      end
      if (pop) begin
         idx_in = '0;
         cnt_in = '0;
      end else begin
         cnt_in = cnt_ff + 3'd1;
      end
      // the head leaves the queue only when its last character is taken
      pop          = pop & fire;
      out_valid_in = fire | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         nl_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            col_ff     <= col_in;
            idx_ff     <= idx_in;
            cnt_ff     <= cnt_in;
            nl_pend_ff <= nl_pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_char_ff <= ch;
         out_last_ff <= lst;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== design/base64_pem_encoder_top.sv =====
// Base64 encoder with PEM line wrapping.
// Request channel (req_): one raw message byte per request, req_tlast on the
// final byte of a message. Response channel (rsp_): one ASCII character per
// response: base64 symbols, '=' padding and newlines; rsp_tlast marks the
// final character of the encoded message.
// A newline follows every LINE_CHARS characters; the final byte flushes the
// partial group with padding and closes the line with a newline.
// Characters leave the queue through the back sequencer's single output
// register, one per cycle while a byte is queued and the receiver is ready.
// A byte yields 1 to 2 characters (about 1.33 on average) plus one per
// newline; the final byte yields up to 5 characters.
// The front accepts a byte every cycle while the 4-entry queue has room.
// Reset clears group position, leftover bits, line column and the queue.
// When the receiver stalls, the response holds and the queue absorbs up to
// four bytes before req_tready drops.
module base64_pem_encoder_top #(
   parameter int LINE_CHARS = b64pem_pkg::LineCharsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   output logic       rsp_tlast
);
   import b64pem_pkg::*;

   b64pem_entry_type push_entry, head_entry;
   logic             push_valid, push_ready, head_valid, pop;

   b64pem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   b64pem_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   b64pem_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/b64pem_checker.sv =====
module b64pem_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >= 8'h41 && rsp_tdata <= 8'h5A)
                  || (rsp_tdata >= 8'h61 && rsp_tdata <= 8'h7A)
                  || (rsp_tdata >= 8'h30 && rsp_tdata <= 8'h39)
                  || rsp_tdata == 8'h2B || rsp_tdata == 8'h2F
                  || rsp_tdata == 8'h3D || rsp_tdata == 8'h0A)
      else $error("illegal output character");

endmodule

bind base64_pem_encoder_top b64pem_checker u_b64pem_checker (.*);

// ===== dv/pem_char_checker.sv =====
module pem_char_checker
   import b64pem_pkg::*;
#(
   parameter int LINE_CHARS = LineCharsDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [6:0] out_char, [7] zero
   input  logic       rsp_tlast,
   output int         mismatches,
   output int         chars_owed
);

   typedef struct packed {
      logic [6:0] code;
      logic       fin;
   } pem_char_type;

   localparam string Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   pem_char_type expected_chars[$];
   logic [1:0]   group_pos;
   logic [3:0]   carry_bits;
   int           column;
   int           step_count;
   int           err_count;

   // a request yields at most MaxResults characters; the rest are dropped
   function automatic void add_raw(input logic [6:0] c);
      pem_char_type e;
      if (step_count < MaxResults) begin
         e.code = c;
         e.fin  = 1'b0;
         expected_chars = {expected_chars, e};
         step_count++;
      end
   endfunction

   // every character counts toward the line; wrap right after it fills up
   function automatic void add_char(input logic [6:0] c);
      add_raw(c);
      column++;
      if (column >= LINE_CHARS) begin
         add_raw(CharNewline);
         column = 0;
      end
   endfunction

   function automatic void add_sextet(input logic [5:0] v);
      logic [7:0] a;
      a = Alphabet[int'(v)];
      add_char(a[6:0]);
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      step_count = 0;
      case (group_pos)
         2'd0: begin
            add_sextet(b[7:2]);
            carry_bits = {2'b00, b[1:0]};
            group_pos  = 2'd1;
         end
         2'd1: begin
            add_sextet({carry_bits[1:0], b[7:4]});
            carry_bits = b[3:0];
            group_pos  = 2'd2;
         end
         default: begin
            add_sextet({carry_bits[3:0], b[7:6]});
            add_sextet(b[5:0]);
            carry_bits = 4'd0;
            group_pos  = 2'd0;
         end
      endcase
      if (fin) begin
         if (group_pos == 2'd1) begin
            add_sextet({carry_bits[1:0], 4'b0000});
            add_char(CharPad);
            add_char(CharPad);
         end else if (group_pos == 2'd2) begin
            add_sextet({carry_bits[3:0], 2'b00});
            add_char(CharPad);
         end
         // a message ending on a full line already got its newline
         if (column != 0) begin
            add_raw(CharNewline);
         end
         if (step_count > 0) begin
            expected_chars[expected_chars.size() - 1].fin = 1'b1;
         end
         group_pos  = 2'd0;
         carry_bits = 4'd0;
         column     = 0;
      end
   endfunction

   always @(posedge clock) begin
      pem_char_type want;
      if (reset) begin
         expected_chars.delete();
         group_pos  = 2'd0;
         carry_bits = 4'd0;
         column     = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               if (err_count < 10) begin
                  $display("unexpected char %h last %b", rsp_tdata[6:0], rsp_tlast);
               end
               err_count++;
            end else begin
               want = expected_chars.pop_front();
               if (want.code != rsp_tdata[6:0] || want.fin != rsp_tlast) begin
                  if (err_count < 10) begin
                     $display("char mismatch: expected %h last %b, got %h last %b",
                              want.code, want.fin, rsp_tdata[6:0], rsp_tlast);
                  end
                  err_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
      end
      mismatches <= err_count;
      chars_owed <= expected_chars.size();
   end

   initial begin
      err_count  = 0;
      step_count = 0;
      group_pos  = 2'd0;
      carry_bits = 4'd0;
      column     = 0;
   end

endmodule

// ===== dv/tb.sv =====
module tb;
   import b64pem_pkg::*;

   localparam int LineChars  = LineCharsDefault;
   localparam int ByteBudget = 230;
   localparam int CalmAfter  = 190;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int         mismatches;
   int         chars_owed;
   int         bytes_sent = 0;
   bit         calm       = 1'b0;
   int         stall_left = 0;
   logic [7:0] msg_bytes[$];

   base64_pem_encoder_top #(
      .LINE_CHARS(LineChars)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   pem_char_checker #(
      .LINE_CHARS(LineChars)
   ) i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .mismatches(mismatches),
      .chars_owed(chars_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (bytes_sent >= CalmAfter) begin
         calm = 1'b1;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_message();
      int n;
      n = msg_bytes.size();
      for (int k = 0; k < n; k++) begin
         send_byte(msg_bytes[k], k == n - 1);
      end
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (chars_owed != 0) @(negedge clock);
   endtask

   initial begin
      int msg_len;
      int pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one-byte, two-byte and three-byte endings, alphabet extremes
      msg_bytes = '{8'h00};
      send_message();
      msg_bytes = '{8'hFF};
      send_message();
      msg_bytes = '{8'hFF, 8'h00};
      send_message();
      msg_bytes = '{8'h00, 8'hFF, 8'h00};
      send_message();
      msg_bytes = '{8'hFB, 8'hEF, 8'hBE};
      send_message();
      msg_bytes = '{8'hFF, 8'hFF, 8'hFF};
      send_message();
      msg_bytes = '{8'h80, 8'h40, 8'h20, 8'h10};
      send_message();
      drain_requests();

      while (bytes_sent < ByteBudget) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            msg_len = $urandom_range(1, 12);
         end else if (pick < 9) begin
            // 45..49 bytes end around one full line
            msg_len = $urandom_range(45, 49);
         end else begin
            msg_len = $urandom_range(93, 97);
         end
         if (msg_len > ByteBudget - bytes_sent) begin
            msg_len = ByteBudget - bytes_sent;
         end
         msg_bytes.delete();
         repeat (msg_len) msg_bytes = {msg_bytes, 8'($urandom_range(0, 255))};
         send_message();
      end
      req_tvalid <= 1'b0;

      drain_requests();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && chars_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
